// File: rtl/wildcard_pattern_match_assert.svh
// Assertion macros used by the wildcard matcher checker.
`ifndef WILDCARD_PATTERN_MATCH_ASSERT_SVH
`define WILDCARD_PATTERN_MATCH_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define WPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wildcard matcher check failed");

// Consequent checked in the cycle after the antecedent.
`define WPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wildcard matcher check failed");

`endif

// File: rtl/wpm_pkg.sv
// Shared types and constants of the wildcard pattern matcher.
package wpm_pkg;

   localparam int OP_W  = 2;
   localparam int POS_W = 5;
   localparam int SYM_W = 8;
   localparam int LEN_W = 6;

   localparam int PATTERN_MAX_DEF = 32;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_LEN   = 2'd1;
   localparam logic [OP_W-1:0] OP_SUBJ  = 2'd2;
   localparam logic [OP_W-1:0] OP_END   = 2'd3;

   localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;
   localparam logic [SYM_W-1:0] ANY_BYTE  = 8'h3F;
   localparam logic [SYM_W-1:0] DOT_BYTE  = 8'h2E;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic write_en;
      logic len_en;
      logic step_en;
      logic restart;
   } ctrl_type;

   // What each cell reports back for the star closure.
   typedef struct packed {
      logic star;
      logic active;
   } cell_stat_type;

endpackage

// File: rtl/wpm_cell.sv
// One pattern position: its byte, its in-use flag and its active flag.
module wpm_cell import wpm_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_type         ctrl_i,
   input  logic [POS_W-1:0] position_i,
   input  logic [SYM_W-1:0] symbol_i,
   input  logic [LEN_W-1:0] pattern_len_i,
   input  logic             closed_i,
   input  logic             adv_i,
   output cell_stat_type    stat_o,
   output logic             adv_o
);

   logic [SYM_W-1:0] byte_ff, byte_in;
   logic             in_use_ff, in_use_in;
   logic             act_ff, act_in;
   logic             is_star;
   logic             hit;

   assign is_star = in_use_ff & (byte_ff == STAR_BYTE);
   assign hit     = (byte_ff == symbol_i) | ((byte_ff == ANY_BYTE) & (symbol_i != DOT_BYTE));
   // a literal or '?' that matches moves the word on to the next position
   assign adv_o   = closed_i & in_use_ff & (byte_ff != STAR_BYTE) & hit;

   assign stat_o.star   = is_star;
   assign stat_o.active = act_ff;

   always_comb begin
      byte_in   = byte_ff;
      in_use_in = in_use_ff;
      act_in    = act_ff;
      if (ctrl_i.write_en && (int'(position_i) == INDEX)) begin
         byte_in = symbol_i;
      end
      if (ctrl_i.len_en) begin
         in_use_in = int'(pattern_len_i) > INDEX;
      end
      if (ctrl_i.restart) begin
         act_in = (INDEX == 0);
      end else if (ctrl_i.step_en) begin
         // a star keeps its own position, any run length
         act_in = (closed_i & is_star) | adv_i;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= 1'b0;
         act_ff    <= (INDEX == 0);
      end else begin
         in_use_ff <= in_use_in;
         act_ff    <= act_in;
      end
   end

endmodule

// File: rtl/wpm_star_close.sv
// Star closure of the active set, computed on the carry chain of one add.
module wpm_star_close #(
   parameter int WIDTH = 33
) (
   input  logic [WIDTH-1:0] star_i,
   input  logic [WIDTH-1:0] act_i,
   output logic [WIDTH-1:0] closed_o
);

   logic [WIDTH-1:0] gen;
   logic [WIDTH-1:0] sum;
   logic [WIDTH-1:0] carry;

   // carry into bit p+1 = star[p] & (act[p] | carry into p): propagate on
   // star, generate on active star
   assign gen      = star_i & act_i;
   assign sum      = star_i + gen;
   assign carry    = sum ^ star_i ^ gen;
   assign closed_o = act_i | carry;

endmodule

// File: rtl/wildcard_pattern_match.sv
// Top level of the wildcard pattern matcher: cell row, closure and result register.
//
//   channel | ports                                          | direction
//   req     | req_valid req_ready req_op req_position        | in
//           | req_symbol req_pattern_len                     |
//   rsp     | rsp_valid rsp_ready rsp_matched                | out
//
// One word per cycle on every op while req_ready is high. The active set of all
// positions updates at once; the star closure rides on one PATTERN_MAX+1 bit add.
// An end-of-subject word shows its result in the cycle after acceptance.
// Reset clears the pattern length to zero and leaves only position zero active;
// pattern bytes are not cleared and must be written before use.
// A waiting result stalls only further end-of-subject words.
module wildcard_pattern_match import wpm_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [OP_W-1:0]  req_op,
   input  logic [POS_W-1:0] req_position,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic [LEN_W-1:0] req_pattern_len,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_matched
);

   localparam int SIZE_W = $clog2(PATTERN_MAX + 1);

   logic                  accept;
   ctrl_type              ctrl;
   logic [PATTERN_MAX:0]  adv;
   cell_stat_type         stat [PATTERN_MAX];
   logic [PATTERN_MAX:0]  star_vec;
   logic [PATTERN_MAX:0]  act_vec;
   logic [PATTERN_MAX:0]  closed;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic                  tail_ff, tail_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_matched_ff, rsp_matched_in;

   assign req_ready = ~rsp_valid_ff | rsp_ready | (req_op != OP_END);
   assign accept    = req_valid & req_ready;

   assign ctrl.write_en = accept & (req_op == OP_WRITE);
   assign ctrl.len_en   = accept & (req_op == OP_LEN);
   assign ctrl.step_en  = accept & (req_op == OP_SUBJ);
   assign ctrl.restart  = accept & (req_op != OP_SUBJ);

   assign adv[0] = 1'b0;

   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
      wpm_cell #(
         .INDEX(g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl_i        (ctrl),
         .position_i    (req_position),
         .symbol_i      (req_symbol),
         .pattern_len_i (req_pattern_len),
         .closed_i      (closed[g]),
         .adv_i         (adv[g]),
         .stat_o        (stat[g]),
         .adv_o         (adv[g+1])
      );
      assign star_vec[g] = stat[g].star;
      assign act_vec[g]  = stat[g].active;
   end

   // position PATTERN_MAX holds no byte, only the accept flag
   assign star_vec[PATTERN_MAX] = 1'b0;
   assign act_vec[PATTERN_MAX]  = tail_ff;

   wpm_star_close #(
      .WIDTH(PATTERN_MAX + 1)
   ) u_close (
      .star_i   (star_vec),
      .act_i    (act_vec),
      .closed_o (closed)
   );

   always_comb begin
      size_in = size_ff;
      if (ctrl.len_en) begin
         size_in = (int'(req_pattern_len) > PATTERN_MAX) ? SIZE_W'(PATTERN_MAX)
                                                         : SIZE_W'(req_pattern_len);
      end
   end

   always_comb begin
      tail_in = tail_ff;
      if (ctrl.restart) begin
         tail_in = 1'b0;
      end else if (ctrl.step_en) begin
         tail_in = adv[PATTERN_MAX];
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      if (accept && (req_op == OP_END)) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = closed[size_ff];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         tail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

endmodule

// File: rtl/wpm_checker.sv
// Port-level checks of the wildcard matcher and their bind to the top level.
`include "wildcard_pattern_match_assert.svh"

module wpm_checker import wpm_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic [OP_W-1:0] req_op,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic            rsp_matched
);

   logic end_taken;

   assign end_taken = req_valid & req_ready & (req_op == OP_END);

   `WPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_matched))
   `WPM_ASSERT_NEXT(a_end_gives_rsp, clock, reset, end_taken, rsp_valid)
   `WPM_ASSERT_NOW(a_rsp_has_cause, clock, reset, $rose(rsp_valid), $past(end_taken))
   `WPM_ASSERT_NEXT(a_no_extra_rsp, clock, reset, rsp_valid && rsp_ready, !rsp_valid || $past(end_taken))

endmodule

bind wildcard_pattern_match wpm_checker u_checker (.*);
